// ===== design/imuta_pkg.sv =====
// Package for the IMU accel-to-gyro time alignment block.
// Holds the shared constants, the controller state type and the command/status structs.
// No dependencies.
`default_nettype none

package imuta_pkg;

    // Default field widths.
    localparam int TIME_BITS_DEF   = 48;
    localparam int SAMPLE_BITS_DEF = 32;

    // The weights are multiplied in chunks of this many bits, one chunk per cycle.
    localparam int CHUNK_BITS = 16;

    localparam int NUM_AXES = 3;

    // Sample kind codes on cmd.
    localparam logic CMD_ACCEL = 1'b0;
    localparam logic CMD_GYRO  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic load_w;
        logic mul_step;
        logic div_init;
        logic div_step;
        logic gyro_commit;
        logic accel_commit;
        logic out_load;
    } dp_cmd_t;

    // Commands from the datapath to each axis lane.
    typedef struct packed {
        logic clear;
        logic mul_step;
        logic div_init;
        logic div_step;
    } lane_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_gyro;
        logic hit;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/imuta_lane.sv =====
// One axis of the interpolation arithmetic: chunked multiply-accumulate and restoring divider.
// Depends on imuta_pkg.
`default_nettype none

module imuta_lane
    import imuta_pkg::*;
#(
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire lane_cmd_t                     cmd,
    input  wire logic [CHUNK_BITS-1:0]         chunk_old,
    input  wire logic [CHUNK_BITS-1:0]         chunk_new,
    input  wire logic signed [SAMPLE_BITS-1:0] prev,
    input  wire logic signed [SAMPLE_BITS-1:0] cur,
    input  wire logic [TIME_BITS-1:0]          divisor,
    output logic signed [SAMPLE_BITS-1:0]      result
);

    localparam int NW = TIME_BITS + SAMPLE_BITS + 1;
    localparam int PW = CHUNK_BITS + 1 + SAMPLE_BITS;

    logic signed [NW-1:0]      acc_reg;
    logic signed [NW-1:0]      acc_next;
    logic signed [PW-1:0]      prod_old;
    logic signed [PW-1:0]      prod_new;
    logic [NW-1:0]             mag;
    logic                      neg_reg;
    logic [TIME_BITS-1:0]      rem_reg;
    logic [SAMPLE_BITS-1:0]    quo_reg;
    logic [TIME_BITS:0]        trial;
    logic [TIME_BITS:0]        diff;
    logic                      ge;

    // Both weights advance one chunk per step, most significant chunk first.
    assign prod_old = PW'($signed({1'b0, chunk_old})) * PW'(prev);
    assign prod_new = PW'($signed({1'b0, chunk_new})) * PW'(cur);
    assign acc_next = (acc_reg <<< CHUNK_BITS) + NW'(prod_old) + NW'(prod_new);

    assign mag = acc_reg[NW-1] ? NW'(-acc_reg) : NW'(acc_reg);

    // The quotient is known to fit the sample width, so the upper part of the
    // numerator is already below the divisor and only SAMPLE_BITS steps are needed.
    assign trial = {rem_reg, quo_reg[SAMPLE_BITS-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            acc_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            acc_reg <= acc_next;
        end

        if (cmd.div_init)
        begin
            neg_reg <= acc_reg[NW-1];
            rem_reg <= mag[NW-2:SAMPLE_BITS];
            quo_reg <= mag[SAMPLE_BITS-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            quo_reg <= {quo_reg[SAMPLE_BITS-2:0], ge};
        end
    end

    assign result = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

`default_nettype wire

// ===== design/imuta_dp.sv =====
// Datapath of the alignment block: input capture, held state, weights, three axis lanes
// and the output register. Depends on imuta_pkg and imuta_lane.
`default_nettype none

module imuta_dp
    import imuta_pkg::*;
#(
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dp_cmd_t                       cmd_in,
    output dp_stat_t                           stat,
    input  wire logic                          in_cmd,
    input  wire logic [TIME_BITS-1:0]          in_time,
    input  wire logic signed [SAMPLE_BITS-1:0] in_v [NUM_AXES],
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [TIME_BITS-1:0]               out_time,
    output logic signed [SAMPLE_BITS-1:0]      out_accel [NUM_AXES],
    output logic signed [SAMPLE_BITS-1:0]      out_gyro [NUM_AXES]
);

    localparam int NCH  = (TIME_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PADW = NCH * CHUNK_BITS;

    logic                          cmd_reg;
    logic [TIME_BITS-1:0]          time_reg;
    logic signed [SAMPLE_BITS-1:0] v_reg [NUM_AXES];
    logic [TIME_BITS-1:0]          gyro_time_reg;
    logic [TIME_BITS-1:0]          accel_time_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] gyro_reg [NUM_AXES];
    logic [PADW-1:0]               w_old_reg;
    logic [PADW-1:0]               w_new_reg;
    logic [TIME_BITS-1:0]          d_reg;
    logic                          out_valid_reg;
    logic [TIME_BITS-1:0]          out_time_reg;
    logic signed [SAMPLE_BITS-1:0] out_accel_reg [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] out_gyro_reg [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] lane_res [NUM_AXES];
    lane_cmd_t                     lane_cmd;

    assign stat.is_gyro  = (cmd_reg == CMD_GYRO);
    assign stat.hit      = (gyro_time_reg != '0) && (gyro_time_reg <= time_reg) &&
                           (accel_time_reg < gyro_time_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign lane_cmd.clear    = cmd_in.load_w;
    assign lane_cmd.mul_step = cmd_in.mul_step;
    assign lane_cmd.div_init = cmd_in.div_init;
    assign lane_cmd.div_step = cmd_in.div_step;

    // Held state has a defined reset value of zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_time_reg  <= '0;
            accel_time_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                prev_reg[i] <= '0;
                gyro_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd_in.gyro_commit)
            begin
                gyro_time_reg <= time_reg;
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    gyro_reg[i] <= v_reg[i];
                end
            end
            if (cmd_in.accel_commit)
            begin
                accel_time_reg <= time_reg;
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    prev_reg[i] <= v_reg[i];
                end
            end
            if (cmd_in.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_in.capture)
        begin
            cmd_reg  <= in_cmd;
            time_reg <= in_time;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                v_reg[i] <= in_v[i];
            end
        end

        if (cmd_in.load_w)
        begin
            w_old_reg <= PADW'(time_reg - gyro_time_reg);
            w_new_reg <= PADW'(gyro_time_reg - accel_time_reg);
            d_reg     <= time_reg - accel_time_reg;
        end
        else if (cmd_in.mul_step)
        begin
            w_old_reg <= w_old_reg << CHUNK_BITS;
            w_new_reg <= w_new_reg << CHUNK_BITS;
        end

        if (cmd_in.out_load)
        begin
            out_time_reg <= gyro_time_reg;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                out_accel_reg[i] <= lane_res[i];
                out_gyro_reg[i]  <= gyro_reg[i];
            end
        end
    end

    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_lane
        imuta_lane #(
            .TIME_BITS   (TIME_BITS),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .clk       (clk),
            .cmd       (lane_cmd),
            .chunk_old (w_old_reg[PADW-1 -: CHUNK_BITS]),
            .chunk_new (w_new_reg[PADW-1 -: CHUNK_BITS]),
            .prev      (prev_reg[g]),
            .cur       (v_reg[g]),
            .divisor   (d_reg),
            .result    (lane_res[g])
        );
    end

    assign out_valid = out_valid_reg;
    assign out_time  = out_time_reg;
    assign out_accel = out_accel_reg;
    assign out_gyro  = out_gyro_reg;

endmodule

`default_nettype wire

// ===== design/imuta_ctrl.sv =====
// Controller state machine of the alignment block: sequences capture, check,
// multiply, divide and output load. Depends on imuta_pkg.
`default_nettype none

module imuta_ctrl
    import imuta_pkg::*;
#(
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd_out
);

    localparam int NCH   = (TIME_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int STEPS = (NCH > SAMPLE_BITS) ? NCH : SAMPLE_BITS;
    localparam int CNT_W = $clog2(STEPS);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd_out    = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_out.capture = 1'b1;
                    state_next      = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.is_gyro)
                begin
                    cmd_out.gyro_commit = 1'b1;
                    state_next          = ST_IDLE;
                end
                else if (!stat.hit)
                begin
                    cmd_out.accel_commit = 1'b1;
                    state_next           = ST_IDLE;
                end
                else
                begin
                    cmd_out.load_w = 1'b1;
                    cnt_next       = '0;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd_out.mul_step = 1'b1;
                if (cnt_reg == CNT_W'(NCH - 1))
                begin
                    state_next = ST_DIV_INIT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DIV_INIT:
            begin
                cmd_out.div_init = 1'b1;
                cnt_next         = '0;
                state_next       = ST_DIV;
            end
            ST_DIV:
            begin
                cmd_out.div_step = 1'b1;
                if (cnt_reg == CNT_W'(SAMPLE_BITS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                // Wait until the output register is free, then hand over the result
                // and replace the stored previous accel sample.
                if (stat.out_free)
                begin
                    cmd_out.out_load     = 1'b1;
                    cmd_out.accel_commit = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/imu_accel_gyro_time_align.sv =====
// IMU accel-to-gyro time alignment, top level. A result appears on out_valid after its
// accel request is captured and checked and has run the chunked multiply, the bit-per-cycle
// divider and the output load, which waits for a free output register. New requests are
// accepted only in the idle state: gyro requests and accel requests that give no result
// return to idle after the check state, one that gives a result only after its output load.
// Reset (rst_n, asynchronous, active low) clears the held gyro and accel state to zero.
`default_nettype none

module imu_accel_gyro_time_align
    import imuta_pkg::*;
#(
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          cmd,
    input  wire logic [TIME_BITS-1:0]          stamp_us,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_x,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_y,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_z,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [TIME_BITS-1:0]               out_time_us,
    output logic signed [SAMPLE_BITS-1:0]      accel_x,
    output logic signed [SAMPLE_BITS-1:0]      accel_y,
    output logic signed [SAMPLE_BITS-1:0]      accel_z,
    output logic signed [SAMPLE_BITS-1:0]      gyro_x,
    output logic signed [SAMPLE_BITS-1:0]      gyro_y,
    output logic signed [SAMPLE_BITS-1:0]      gyro_z
);

    // The controller only sequences; all arithmetic and held state sit in the datapath.
    // A gyro request is captured and then stored. An accel request is checked against the held
    // gyro time, and when the gyro time falls inside the accel interval the acceleration
    // is interpolated per axis as ((t-g)*prev + (g-p)*new) / (t-p), truncated toward zero.

    dp_cmd_t                       dp_cmd;
    dp_stat_t                      dp_stat;
    logic signed [SAMPLE_BITS-1:0] in_v [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] acc_out [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] gyr_out [NUM_AXES];

    assign in_v[0] = sample_x;
    assign in_v[1] = sample_y;
    assign in_v[2] = sample_z;

    imuta_ctrl #(
        .TIME_BITS   (TIME_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (dp_stat),
        .cmd_out  (dp_cmd)
    );

    imuta_dp #(
        .TIME_BITS   (TIME_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_in    (dp_cmd),
        .stat      (dp_stat),
        .in_cmd    (cmd),
        .in_time   (stamp_us),
        .in_v      (in_v),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_time  (out_time_us),
        .out_accel (acc_out),
        .out_gyro  (gyr_out)
    );

    assign accel_x = acc_out[0];
    assign accel_y = acc_out[1];
    assign accel_z = acc_out[2];
    assign gyro_x  = gyr_out[0];
    assign gyro_y  = gyr_out[1];
    assign gyro_z  = gyr_out[2];

endmodule

`default_nettype wire
